>>> rtl/core/lepg_pkg.sv
// Package for the LED effect pixel generator: codes, defaults, sine table.
`default_nettype none
package lepg_pkg;

    typedef enum logic [2:0] {
        EFFECT_SOLID    = 3'd0,
        EFFECT_BREATHE  = 3'd1,
        EFFECT_FADE     = 3'd2,
        EFFECT_CHASE    = 3'd3,
        EFFECT_PROGRESS = 3'd4,
        EFFECT_BLINK    = 3'd5,
        EFFECT_OFF      = 3'd6
    } effect_mode_t;

    typedef enum logic [2:0] {
        REG_EFFECT_MODE      = 3'd0,
        REG_PRIMARY_COLOR    = 3'd1,
        REG_SECONDARY_COLOR  = 3'd2,
        REG_BRIGHTNESS       = 3'd3,
        REG_SPEED            = 3'd4,
        REG_PROGRESS_PERCENT = 3'd5,
        REG_LED_COUNT        = 3'd6
    } cfg_reg_t;

    localparam int LED_LIMIT_DEF        = 1024;
    localparam int TAIL_LENGTH_DEF      = 6;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int TIME_W      = 32;
    localparam int PIX_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int DVS_W       = 14;

    localparam logic [2:0]  RST_EFFECT_MODE      = EFFECT_BREATHE;
    localparam logic [23:0] RST_PRIMARY_COLOR    = 24'h202020;
    localparam logic [23:0] RST_SECONDARY_COLOR  = 24'h000000;
    localparam logic [7:0]  RST_BRIGHTNESS       = 8'd64;
    localparam logic [7:0]  RST_SPEED            = 8'd40;
    localparam logic [7:0]  RST_PROGRESS_PERCENT = 8'd0;
    localparam logic [10:0] RST_LED_COUNT        = 11'd1;

    // Timing constants of the effects
    localparam int BREATHE_STEP_MS = 25;
    localparam int BREATHE_FLOOR   = 20;
    localparam int FADE_STEP_MS    = 40;
    localparam int FADE_MIN_MS     = 300;
    localparam int BLINK_STEP_MS   = 10;
    localparam int BLINK_MIN_MS    = 100;
    localparam int CHASE_BASE_MS   = 260;
    localparam int CHASE_STEP_MS   = 5;
    localparam int CHASE_MIN_MS    = 40;
    localparam int CHASE_MAX_SPEED = 44;
    localparam int PERCENT_FULL    = 100;

    // lit = x / 100 as (x * M) >> K for x below 2^19
    localparam int          PCT_SHIFT = 26;
    localparam logic [63:0] PCT_MULT  =
        ((64'd1 << PCT_SHIFT) + 64'(PERCENT_FULL) - 64'd1) / 64'(PERCENT_FULL);

    localparam logic [14:0] QSINE [65] = '{
        15'd0, 15'd804, 15'd1608, 15'd2410, 15'd3212, 15'd4011, 15'd4808, 15'd5602,
        15'd6393, 15'd7179, 15'd7962, 15'd8740, 15'd9512, 15'd10278, 15'd11039,
        15'd11793, 15'd12540, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151,
        15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20788,
        15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279, 15'd24811,
        15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683, 15'd28105,
        15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273, 15'd30571,
        15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971, 15'd32137,
        15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
        15'd32767
    };

    // Sine of phase k (256 per turn) offset by 32768, so always 1..65535
    function automatic logic [15:0] sine_offset(input logic [7:0] k);
        logic [5:0]  r;
        logic [14:0] v;
        r = k[5:0];
        v = k[6] ? QSINE[7'd64 - {1'b0, r}] : QSINE[r];
        return k[7] ? (16'd32768 - {1'b0, v}) : (16'd32768 + {1'b0, v});
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lepg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`default_nettype none
module lepg_div_pipe #(
    parameter int DVD_W  = 32,
    parameter int DVS_W  = 14,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DVD_W-1:0]  in_dividend,
    input  wire logic [DVS_W-1:0]  in_divisor,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [DVD_W-1:0]       out_quot,
    output logic [DVS_W-1:0]       out_rem,
    output logic [SIDE_W-1:0]      out_side
);

    logic              v_reg [DVD_W];
    logic [DVD_W-1:0]  w_reg [DVD_W];
    logic [DVS_W-1:0]  r_reg [DVD_W];
    logic [DVS_W-1:0]  d_reg [DVD_W];
    logic [SIDE_W-1:0] s_reg [DVD_W];

    for (genvar i = 0; i < DVD_W; i++) begin : g_stage
        logic              v_in;
        logic [DVD_W-1:0]  w_in;
        logic [DVS_W-1:0]  r_in;
        logic [DVS_W-1:0]  d_in;
        logic [SIDE_W-1:0] s_in;
        logic [DVS_W:0]    trial;
        logic              fits;
        logic [DVD_W-1:0]  w_next;
        logic [DVS_W-1:0]  r_next;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign w_in = in_dividend;
            assign r_in = '0;
            assign d_in = in_divisor;
            assign s_in = in_side;
        end else begin : g_rest
            assign v_in = v_reg[i-1];
            assign w_in = w_reg[i-1];
            assign r_in = r_reg[i-1];
            assign d_in = d_reg[i-1];
            assign s_in = s_reg[i-1];
        end

        // Shift the next dividend bit into the partial remainder
        assign trial  = {r_in, w_in[DVD_W-1]};
        assign fits   = trial >= {1'b0, d_in};
        assign w_next = {w_in[DVD_W-2:0], fits};
        assign r_next = fits ? DVS_W'(trial - {1'b0, d_in}) : trial[DVS_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                w_reg[i] <= w_next;
                r_reg[i] <= r_next;
                d_reg[i] <= d_in;
                s_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[DVD_W-1];
    assign out_quot  = w_reg[DVD_W-1];
    assign out_rem   = r_reg[DVD_W-1];
    assign out_side  = s_reg[DVD_W-1];

endmodule
`default_nettype wire

>>> rtl/core/led_effect_pixel_generator_unit.sv
// Top level of the LED effect pixel generator: config registers and pixel pipeline.
//
// One pixel per clock: every cycle a (time_ms, pixel_index) beat may enter and
// its RGB beat is presented once it has passed through 71 register
// stages (input register, a 32-stage divider for the time period, one setup
// stage, a second 32-stage divider for phase, head and ramp, four stages of
// table lookup and scaling, and the output register). The whole pipeline
// advances together; it holds while a result waits on m_ready. Configuration
// writes are taken every cycle and must land while no pixel is in flight.
`default_nettype none
module led_effect_pixel_generator_unit #(
    parameter int LED_LIMIT        = lepg_pkg::LED_LIMIT_DEF,
    parameter int TAIL_LENGTH      = lepg_pkg::TAIL_LENGTH_DEF,
    parameter int SINE_TABLE_DEPTH = lepg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lepg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lepg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lepg_pkg::TIME_W-1:0]      s_time_ms,
    input  wire logic [lepg_pkg::PIX_W-1:0]       s_pixel_index,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_red,
    output logic [7:0]                            m_green,
    output logic [7:0]                            m_blue
);
    import lepg_pkg::*;

    localparam int JW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int SINE_SHIFT = 33;
    localparam logic [63:0] SINE_MULT =
        ((64'd1 << SINE_SHIFT) + 64'(SINE_TABLE_DEPTH) - 64'd1) / 64'(SINE_TABLE_DEPTH);
    localparam int TAIL_SHIFT = 22;
    localparam logic [63:0] TAIL_MULT =
        ((64'd1 << TAIL_SHIFT) + 64'(TAIL_LENGTH) - 64'd1) / 64'(TAIL_LENGTH);

    // Configuration registers
    logic [2:0]  effect_mode_reg;
    logic [23:0] primary_color_reg;
    logic [23:0] secondary_color_reg;
    logic [7:0]  brightness_reg;
    logic [7:0]  speed_reg;
    logic [7:0]  progress_percent_reg;
    logic [10:0] led_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            effect_mode_reg      <= RST_EFFECT_MODE;
            primary_color_reg    <= RST_PRIMARY_COLOR;
            secondary_color_reg  <= RST_SECONDARY_COLOR;
            brightness_reg       <= RST_BRIGHTNESS;
            speed_reg            <= RST_SPEED;
            progress_percent_reg <= RST_PROGRESS_PERCENT;
            led_count_reg        <= RST_LED_COUNT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_EFFECT_MODE:      effect_mode_reg      <= cfg_data[2:0];
                REG_PRIMARY_COLOR:    primary_color_reg    <= cfg_data[23:0];
                REG_SECONDARY_COLOR:  secondary_color_reg  <= cfg_data[23:0];
                REG_BRIGHTNESS:       brightness_reg       <= cfg_data[7:0];
                REG_SPEED:            speed_reg            <= cfg_data[7:0];
                REG_PROGRESS_PERCENT: progress_percent_reg <= cfg_data[7:0];
                REG_LED_COUNT:        led_count_reg        <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Periods derived from config, refreshed every cycle
    logic [DVS_W-1:0] breathe_per_next, fade_per_next, blink_per_next, chase_dly_next;
    logic [DVS_W-1:0] period_next, period_reg;
    logic [DVS_W-1:0] half_reg;
    logic [COUNT_W-1:0] count_next, count_reg;

    always_comb begin
        breathe_per_next = DVS_W'((speed_reg == 8'd0 ? 8'd1 : speed_reg) * BREATHE_STEP_MS);
        fade_per_next    = DVS_W'(speed_reg * FADE_STEP_MS);
        if (fade_per_next < DVS_W'(FADE_MIN_MS)) fade_per_next = DVS_W'(FADE_MIN_MS);
        blink_per_next   = DVS_W'(speed_reg * BLINK_STEP_MS);
        if (blink_per_next < DVS_W'(BLINK_MIN_MS)) blink_per_next = DVS_W'(BLINK_MIN_MS);
        chase_dly_next   = (speed_reg <= 8'(CHASE_MAX_SPEED))
                         ? DVS_W'(CHASE_BASE_MS - CHASE_STEP_MS * int'(speed_reg))
                         : DVS_W'(CHASE_MIN_MS);
        unique case (effect_mode_reg)
            EFFECT_BREATHE: period_next = breathe_per_next;
            EFFECT_FADE:    period_next = fade_per_next;
            EFFECT_CHASE:   period_next = chase_dly_next;
            EFFECT_BLINK:   period_next = blink_per_next;
            default:        period_next = DVS_W'(1);
        endcase
        if (led_count_reg == '0) begin
            count_next = COUNT_W'(1);
        end else if (32'(led_count_reg) > 32'(LED_LIMIT)) begin
            count_next = COUNT_W'(LED_LIMIT);
        end else begin
            count_next = led_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        half_reg   <= fade_per_next >> 1;
        count_reg  <= count_next;
    end

    // Global advance: hold every stage while a result waits
    logic m_valid_reg;
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage 0: input register
    logic             v0_reg;
    logic [TIME_W-1:0] t0_reg;
    logic [PIX_W-1:0] pix0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg   <= s_time_ms;
            pix0_reg <= s_pixel_index;
        end
    end

    // Divider one: time over period
    logic              d1_valid;
    logic [TIME_W-1:0] d1_quot;
    logic [DVS_W-1:0]  d1_rem;
    logic [PIX_W-1:0]  d1_pix;

    lepg_div_pipe #(
        .DVD_W (TIME_W),
        .DVS_W (DVS_W),
        .SIDE_W(PIX_W)
    ) u_div_time (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (v0_reg),
        .in_dividend(t0_reg),
        .in_divisor (period_reg),
        .in_side    (pix0_reg),
        .out_valid  (d1_valid),
        .out_quot   (d1_quot),
        .out_rem    (d1_rem),
        .out_side   (d1_pix)
    );

    // Stage 1: set up the second division
    logic              v1_reg;
    logic [TIME_W-1:0] dvd1_reg;
    logic [DVS_W-1:0]  dvs1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic              blink1_reg;
    logic [TIME_W-1:0] dvd1_next;
    logic [DVS_W-1:0]  dvs1_next;
    logic [DVS_W-1:0]  ramp1;

    always_comb begin
        ramp1 = (d1_rem < half_reg) ? d1_rem : DVS_W'({half_reg, 1'b0} - {1'b0, d1_rem});
        unique case (effect_mode_reg)
            EFFECT_BREATHE: begin
                dvd1_next = TIME_W'(d1_rem) * TIME_W'(SINE_TABLE_DEPTH);
                dvs1_next = period_reg;
            end
            EFFECT_FADE: begin
                dvd1_next = TIME_W'(ramp1) * TIME_W'(brightness_reg);
                dvs1_next = half_reg;
            end
            EFFECT_CHASE: begin
                dvd1_next = d1_quot;
                dvs1_next = DVS_W'(count_reg);
            end
            default: begin
                dvd1_next = '0;
                dvs1_next = DVS_W'(1);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dvd1_reg   <= dvd1_next;
            dvs1_reg   <= dvs1_next;
            pix1_reg   <= d1_pix;
            blink1_reg <= d1_quot[0];
        end
    end

    // Divider two: sine phase, fade ramp or chase head
    logic              d2_valid;
    logic [TIME_W-1:0] d2_quot;
    logic [DVS_W-1:0]  d2_rem;
    logic [PIX_W:0]    d2_side;

    lepg_div_pipe #(
        .DVD_W (TIME_W),
        .DVS_W (DVS_W),
        .SIDE_W(PIX_W + 1)
    ) u_div_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (v1_reg),
        .in_dividend(dvd1_reg),
        .in_divisor (dvs1_reg),
        .in_side    ({blink1_reg, pix1_reg}),
        .out_valid  (d2_valid),
        .out_quot   (d2_quot),
        .out_rem    (d2_rem),
        .out_side   (d2_side)
    );

    // Stage 2: sine index, chase distance, progress product
    logic             v2_reg;
    logic [7:0]       k2_reg;
    logic [11:0]      dist2_reg;
    logic [18:0]      litp2_reg;
    logic [7:0]       fade2_reg;
    logic             blink2_reg;
    logic [PIX_W-1:0] pix2_reg;
    logic [JW+7:0]    kx2;
    logic [63:0]      kprod2;
    logic [11:0]      wrap2;
    logic [11:0]      dist2_next;

    always_comb begin
        kx2    = {d2_quot[JW-1:0], 8'd0};
        kprod2 = 64'(kx2) * SINE_MULT;
        wrap2  = 12'(d2_side[PIX_W-1:0]) + 12'(count_reg) - 12'(d2_rem[COUNT_W-1:0]);
        dist2_next = (wrap2 >= 12'(count_reg)) ? (wrap2 - 12'(count_reg)) : wrap2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k2_reg     <= 8'(kprod2 >> SINE_SHIFT);
            dist2_reg  <= dist2_next;
            litp2_reg  <= 19'(count_reg) * 19'(progress_percent_reg);
            fade2_reg  <= d2_quot[7:0];
            blink2_reg <= d2_side[PIX_W];
            pix2_reg   <= d2_side[PIX_W-1:0];
        end
    end

    // Stage 3: sine lookup, tail product, lit count
    logic             v3_reg;
    logic [15:0]      sine3_reg;
    logic [14:0]      tailx3_reg;
    logic [12:0]      lit3_reg;
    logic [7:0]       fade3_reg;
    logic             blink3_reg;
    logic [PIX_W-1:0] pix3_reg;
    logic [63:0]      litprod3;

    assign litprod3 = 64'(litp2_reg) * PCT_MULT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sine3_reg  <= sine_offset(k2_reg);
            tailx3_reg <= (dist2_reg < 12'(TAIL_LENGTH))
                        ? 15'(7'(TAIL_LENGTH - int'(dist2_reg))) * 15'(brightness_reg)
                        : 15'd0;
            lit3_reg   <= 13'(litprod3 >> PCT_SHIFT);
            fade3_reg  <= fade2_reg;
            blink3_reg <= blink2_reg;
            pix3_reg   <= pix2_reg;
        end
    end

    // Stage 4: per-mode scale and color choice
    logic        v4_reg;
    logic [7:0]  scale4_reg;
    logic [23:0] color4_reg;
    logic [23:0] bprod4;
    logic [8:0]  bsum4;
    logic [7:0]  breathe4;
    logic [63:0] tprod4;
    logic [7:0]  scale4_next;
    logic [23:0] color4_next;

    always_comb begin
        bprod4   = 24'(sine3_reg) * 24'(brightness_reg);
        bsum4    = 9'(bprod4[23:16]) + 9'(BREATHE_FLOOR);
        breathe4 = bsum4[8] ? 8'hFF : bsum4[7:0];
        tprod4   = 64'(tailx3_reg) * TAIL_MULT;
        color4_next = primary_color_reg;
        unique case (effect_mode_reg)
            EFFECT_SOLID:    scale4_next = brightness_reg;
            EFFECT_BREATHE:  scale4_next = breathe4;
            EFFECT_FADE:     scale4_next = fade3_reg;
            EFFECT_CHASE:    scale4_next = 8'(tprod4 >> TAIL_SHIFT);
            EFFECT_PROGRESS: begin
                scale4_next = brightness_reg;
                if (13'(pix3_reg) >= lit3_reg && progress_percent_reg < 8'(PERCENT_FULL)) begin
                    color4_next = secondary_color_reg;
                end
            end
            EFFECT_BLINK:    scale4_next = blink3_reg ? 8'd0 : brightness_reg;
            default:         scale4_next = 8'd0;
        endcase
        // Drop pixels beyond the strip to black
        if (11'(pix3_reg) >= count_reg) scale4_next = 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            scale4_reg <= scale4_next;
            color4_reg <= color4_next;
        end
    end

    // Stage 5: channel products
    logic        v5_reg;
    logic [15:0] pr5_reg, pg5_reg, pb5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr5_reg <= 16'(color4_reg[23:16]) * 16'(scale4_reg);
            pg5_reg <= 16'(color4_reg[15:8])  * 16'(scale4_reg);
            pb5_reg <= 16'(color4_reg[7:0])   * 16'(scale4_reg);
        end
    end

    // Output register: p / 255 as (p + 1 + (p >> 8)) >> 8, exact for p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'd1 + 17'(p[15:8]);
        return s[15:8];
    endfunction

    logic [7:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= div255(pr5_reg);
            green_reg <= div255(pg5_reg);
            blue_reg  <= div255(pb5_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

    a_result_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v5_reg))
        else $error("result appeared without a pipeline beat");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(v5_reg) && $stable(pr5_reg)))
        else $error("last stage moved during stall");

endmodule
`default_nettype wire
